[design/pwaj_pkg.sv]
// Package: shared constants for the ping window average and jitter block.
`default_nettype none
package pwaj_pkg;
  localparam int unsigned WinZeroMeans = 60;
  localparam logic [0:0] OpSample = 1'b0;
  localparam logic [0:0] OpClear  = 1'b1;
  localparam logic [1:0] CfgWindow = 2'd0;
  localparam logic [1:0] CfgPingLim = 2'd1;
  localparam logic [1:0] CfgJitLim = 2'd2;
endpackage
`default_nettype wire

[design/pwaj_div.sv]
// Restoring divider: one quotient bit per cycle.
`default_nettype none
module pwaj_div #(
  parameter int unsigned NumW = 24,
  parameter int unsigned DenW = 9
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 busy_o,
  output logic [NumW-1:0]      quo_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);
  logic [NumW-1:0] quo_q;
  logic [DenW:0]   rem_q;
  logic [DenW-1:0] den_q;
  logic [CntW-1:0] cnt_q;
  logic [DenW:0]   trial;
  assign trial = {rem_q[DenW-1:0], quo_q[NumW-1]};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= CntW'(NumW);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (cnt_q != '0) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= trial - {1'b0, den_q};
        quo_q <= {quo_q[NumW-2:0], 1'b1};
      end else begin
        rem_q <= trial;
        quo_q <= {quo_q[NumW-2:0], 1'b0};
      end
    end
  end
  assign busy_o = (cnt_q != '0);
  assign quo_o = quo_q;
endmodule
`default_nettype wire

[design/ping_window_average_jitter.sv]
// Top level: per-client sliding window mean ping and mean jitter.
// A sample on a full window reads its history, then runs two serial divides
// (mean, then jitter); a clear item or a sample on a window that is not full
// skips both.
// One item at a time: the next item can be accepted from the cycle after the result is
// registered, and a stalled result holds the block. Reset clears per-client valid
// bits so fill counts and held statistics read as zero; no memory is cleared.
`default_nettype none
module ping_window_average_jitter import pwaj_pkg::*; #(
  parameter int unsigned NUM_CLIENTS = 256,
  parameter int unsigned MAX_WINDOW = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [0:0]  opcode_i,
  input  wire logic [7:0]  client_id_i,
  input  wire logic [15:0] ping_ms_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      mean_ping_o,
  output logic [15:0]      mean_jitter_o,
  output logic             window_full_o,
  output logic             ping_over_o,
  output logic             jitter_over_o,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_wdata_i
);
  localparam int unsigned CW = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int unsigned PW = $clog2(MAX_WINDOW);
  localparam int unsigned FW = $clog2(MAX_WINDOW + 1);
  localparam int unsigned AW = CW + PW;
  localparam int unsigned SW = 16 + FW;
  localparam int unsigned RW = FW + PW + 32;
  localparam logic [2:0] SIdle = 3'd0, SLoad = 3'd1, SWalk = 3'd2, SDiv1 = 3'd3,
                         SDiv2 = 3'd4, SPush = 3'd5, SOut = 3'd6;

  logic [6:0] win_q; logic [15:0] plim_q, jlim_q;
  logic [7:0] nraw; logic [FW-1:0] neff;

  logic [2:0] st_q;
  logic [CW-1:0] cl_q; logic [15:0] ping_q; logic op_q, oor_q;
  logic [FW-1:0] cnt_q, idx_q; logic [PW-1:0] hd_q;
  logic [SW-1:0] sum_q, jit_q; logic [15:0] last_q; logic rvalid_q;
  logic full_q; logic [15:0] hm_q, hj_q, rmean_q, rjit_q;
  logic dstart, dstart_d1; logic [SW-1:0] dnum; logic dbusy; logic [SW-1:0] dquo;
  logic [FW-1:0] keep;
  logic in_acc;
  logic [15:0] diff;

  // history as a circular buffer per client; head points at the newest entry
  logic [15:0] hist_mem [2**AW];
  logic [15:0] rd_q;
  logic [AW-1:0] raddr, waddr; logic we;

  // per-client record: fill count, head, held mean, held jitter
  logic [RW-1:0] crec_mem [NUM_CLIENTS];
  logic [RW-1:0] rec_q, rec_wdata; logic rec_we;
  logic [NUM_CLIENTS-1:0] cvld_q; logic rvld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= 7'd30; plim_q <= '0; jlim_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgWindow:  win_q <= cfg_wdata_i[6:0];
        CfgPingLim: plim_q <= cfg_wdata_i;
        CfgJitLim:  jlim_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end
  assign nraw = (win_q == '0) ? 8'(WinZeroMeans) : {1'b0, win_q};
  assign neff = (32'(nraw) > MAX_WINDOW) ? FW'(MAX_WINDOW) : FW'(nraw);

  always_ff @(posedge clk_i) begin
    if (we) hist_mem[waddr] <= ping_q;
    rd_q <= hist_mem[raddr];
  end

  assign in_acc = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i) begin
    if (rec_we) crec_mem[cl_q] <= rec_wdata;
    if (in_acc) rec_q <= crec_mem[CW'(client_id_i)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q <= '0; rvld_q <= 1'b0;
    end else begin
      if (rec_we) cvld_q[cl_q] <= 1'b1;
      if (in_acc) rvld_q <= cvld_q[CW'(client_id_i)];
    end
  end

  pwaj_div #(.NumW(SW), .DenW(FW)) u_div (
    .clk_i, .rst_ni, .start_i(dstart), .num_i(dnum), .den_i(cnt_q),
    .busy_o(dbusy), .quo_o(dquo));

  assign in_stall_o = (st_q != SIdle);
  assign raddr = {cl_q, PW'(hd_q - PW'(idx_q))};
  assign keep = (cnt_q >= neff) ? neff - 1'b1 : cnt_q;
  assign we = (st_q == SPush);
  assign waddr = {cl_q, PW'(hd_q + 1'b1)};
  assign rec_we = (st_q == SPush) || (st_q == SWalk && !oor_q && op_q == OpClear);
  assign rec_wdata = (st_q == SPush) ?
                     {FW'(keep + 1'b1), PW'(hd_q + 1'b1), hm_q, hj_q} :
                     {{FW{1'b0}}, hd_q, 32'd0};
  assign dstart = (st_q == SWalk && !rvalid_q && idx_q == cnt_q) ||
                  (st_q == SDiv1 && !dbusy && !dstart_d1);
  assign dnum = (st_q == SWalk) ? sum_q : jit_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dstart_d1 <= 1'b0; else dstart_d1 <= dstart;
  end

  assign diff = (rd_q > last_q) ? rd_q - last_q : last_q - rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; out_valid_o <= 1'b0; rvalid_q <= 1'b0;
    end else begin
      if (st_q == SOut && (!out_valid_o || !out_stall_i)) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
      unique case (st_q)
        SIdle: if (in_valid_i) begin
          cl_q <= CW'(client_id_i); ping_q <= ping_ms_i; op_q <= opcode_i;
          oor_q <= (32'(client_id_i) >= NUM_CLIENTS);
          st_q <= SLoad;
        end
        SLoad: begin
          cnt_q <= rvld_q ? rec_q[RW-1 -: FW] : '0;
          hd_q <= rvld_q ? rec_q[32 +: PW] : '0;
          hm_q <= rvld_q ? rec_q[16 +: 16] : '0;
          hj_q <= rvld_q ? rec_q[15:0] : '0;
          idx_q <= '0; sum_q <= '0; jit_q <= '0; last_q <= '0;
          rvalid_q <= 1'b0; full_q <= 1'b0;
          st_q <= SWalk;
        end
        SWalk: begin
          if (oor_q) st_q <= SOut;
          else if (op_q == OpClear) begin
            hm_q <= '0; hj_q <= '0;
            st_q <= SOut;
          end else if (cnt_q < neff || cnt_q == '0) st_q <= SPush;
          else begin
            rvalid_q <= (idx_q != cnt_q);
            if (idx_q != cnt_q) idx_q <= idx_q + 1'b1;
            if (rvalid_q) begin
              sum_q <= sum_q + SW'(rd_q);
              if (last_q != '0) jit_q <= jit_q + SW'(diff);
              last_q <= rd_q;
            end
            if (dstart) st_q <= SDiv1;
          end
        end
        SDiv1: if (!dbusy && !dstart_d1) begin
          hm_q <= dquo[15:0]; st_q <= SDiv2;
        end
        SDiv2: if (!dbusy && !dstart_d1) begin
          hj_q <= dquo[15:0]; full_q <= 1'b1; st_q <= SPush;
        end
        SPush: st_q <= SOut;
        SOut: if (!out_valid_o || !out_stall_i) begin
          rmean_q <= (oor_q) ? '0 : hm_q;
          rjit_q <= (oor_q) ? '0 : hj_q;
          window_full_o <= full_q && !oor_q;
          st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end
  assign mean_ping_o = rmean_q;
  assign mean_jitter_o = rjit_q;
  assign ping_over_o = (plim_q != '0) && (rmean_q > plim_q);
  assign jitter_over_o = (jlim_q != '0) && (rjit_q > jlim_q);

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != SIdle) |-> in_stall_o) else $error("accepted while busy");
  a_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |=> (st_q == SOut)) else $error("push not followed by result");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && window_full_o) |-> (rmean_q <= 16'hFFFF)) else $error("bad full");
endmodule
`default_nettype wire

[tb/tb_top.sv]
// Testbench for the per-client ping window mean and jitter block, with its scoreboard.
`timescale 1ns / 100ps
`default_nettype none

typedef struct packed {
  logic [15:0] mean_ping;
  logic [15:0] mean_jitter;
  logic        window_full;
  logic        ping_over;
  logic        jitter_over;
} stats_t;

class ping_stats_board;
  logic [15:0] hist [256][64];
  int unsigned fill [256];
  logic [15:0] mean_h [256];
  logic [15:0] jit_h [256];
  int unsigned win_reg;
  int unsigned ping_lim;
  int unsigned jit_lim;
  stats_t pending [$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned full_seen;

  function new();
    win_reg = 30;
    ping_lim = 0;
    jit_lim = 0;
    mismatches = 0;
    results_seen = 0;
    full_seen = 0;
    for (int c = 0; c < 256; c++) begin
      fill[c] = 0;
      mean_h[c] = '0;
      jit_h[c] = '0;
    end
  endfunction

  function void write_reg(logic [1:0] idx, logic [15:0] val);
    if (idx == pwaj_pkg::CfgWindow) win_reg = 32'(val[6:0]);
    else if (idx == pwaj_pkg::CfgPingLim) ping_lim = 32'(val);
    else if (idx == pwaj_pkg::CfgJitLim) jit_lim = 32'(val);
  endfunction

  function void note_item(logic [0:0] op, logic [7:0] cid, logic [15:0] ping);
    int unsigned n;
    int unsigned cnt;
    int unsigned sum;
    int unsigned jit;
    int unsigned last;
    int unsigned v;
    stats_t r;
    r = '0;
    if (op == pwaj_pkg::OpClear) begin
      fill[cid] = 0;
      mean_h[cid] = '0;
      jit_h[cid] = '0;
    end else begin
      n = (win_reg == 0) ? pwaj_pkg::WinZeroMeans : win_reg;
      if (n > 64) n = 64;
      cnt = fill[cid];
      if (cnt >= n && cnt > 0) begin
        sum = 0;
        jit = 0;
        last = 0;
        for (int i = 0; i < cnt; i++) begin
          v = 32'(hist[cid][i]);
          sum += v;
          if (last != 0) jit += (v > last) ? v - last : last - v;
          last = v;
        end
        mean_h[cid] = 16'(sum / cnt);
        jit_h[cid] = 16'(jit / cnt);
        r.window_full = 1'b1;
      end
      if (cnt >= n) cnt = n - 1;
      for (int i = cnt; i > 0; i--) hist[cid][i] = hist[cid][i-1];
      hist[cid][0] = ping;
      fill[cid] = cnt + 1;
    end
    r.mean_ping = mean_h[cid];
    r.mean_jitter = jit_h[cid];
    r.ping_over = (ping_lim != 0) && (32'(mean_h[cid]) > ping_lim);
    r.jitter_over = (jit_lim != 0) && (32'(jit_h[cid]) > jit_lim);
    pending.push_back(r);
  endfunction

  function void check_result(stats_t got);
    stats_t want;
    results_seen++;
    if (got.window_full) full_seen++;
    if (pending.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("unexpected result %p", got);
      return;
    end
    want = pending.pop_front();
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
    end
  endfunction
endclass

module tb_top;
  import pwaj_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [0:0] opcode_i = '0;
  logic [7:0] client_id_i = '0;
  logic [15:0] ping_ms_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [15:0] mean_ping_o, mean_jitter_o;
  logic window_full_o, ping_over_o, jitter_over_o;
  logic cfg_we_i = 1'b0;
  logic [1:0] cfg_index_i = '0;
  logic [15:0] cfg_wdata_i = '0;

  ping_stats_board board = new();
  int unsigned cycles = 0;
  int unsigned items_sent = 0;
  int unsigned hold_off = 0;
  bit random_stall = 1'b1;
  localparam int unsigned CycleLimit = 2000000;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  ping_window_average_jitter dut (.*);

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk_i)
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result('{mean_ping_o, mean_jitter_o, window_full_o, ping_over_o,
                           jitter_over_o});

  // receiver stall process
  initial begin
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_off) @(negedge clk_i);
        hold_off = 0;
      end
      if (random_stall) begin
        w = $urandom_range(14);
        if ($urandom_range(3) == 0) w = 0;
        out_stall_i <= (w != 0);
        if (w > 1) repeat (w - 1) @(negedge clk_i);
      end else out_stall_i <= 1'b0;
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    board.write_reg(idx, val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_item(logic [0:0] op, logic [7:0] cid, logic [15:0] ping, bit gaps);
    int unsigned g;
    g = gaps ? $urandom_range(14) : 0;
    if (gaps && $urandom_range(3) == 0) g = 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    client_id_i <= cid;
    ping_ms_i <= ping;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_item(op, cid, ping);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
  endtask

  function automatic logic [15:0] rand_ping();
    case ($urandom_range(5))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom_range(65535));
      default: return 16'($urandom_range(400));
    endcase
  endfunction

  initial begin
    int unsigned wins [6];
    logic [7:0] cid;
    wins = '{30, 2, 1, 0, 64, 100};
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed part
    write_cfg(CfgWindow, 16'd2);
    write_cfg(CfgPingLim, 16'd1);
    write_cfg(CfgJitLim, 16'd1);
    send_item(OpSample, 8'd0, 16'hFFFF, 1'b0);
    send_item(OpSample, 8'd0, 16'd0, 1'b0);
    send_item(OpSample, 8'd0, 16'hFFFF, 1'b0);
    send_item(OpSample, 8'd0, 16'd1, 1'b0);
    send_item(OpSample, 8'd255, 16'hFFFF, 1'b0);
    send_item(OpSample, 8'd255, 16'd0, 1'b0);
    send_item(OpSample, 8'd255, 16'd5, 1'b0);
    send_item(OpClear, 8'd0, 16'hABCD, 1'b0);
    send_item(OpSample, 8'd0, 16'd7, 1'b0);
    send_item(OpClear, 8'd255, 16'h5432, 1'b0);
    drain();
    write_cfg(CfgWindow, 16'd4);
    for (int i = 0; i < 6; i++) send_item(OpSample, 8'd3, 16'(i * 1000), 1'b0);
    drain();
    write_cfg(CfgWindow, 16'd2);
    send_item(OpSample, 8'd3, 16'd9, 1'b0);
    send_item(OpSample, 8'd3, 16'd9, 1'b0);
    drain();

    // long receiver hold-off while the sender keeps going
    hold_off = 300;
    for (int i = 0; i < 20; i++) send_item(OpSample, 8'(i % 4), rand_ping(), 1'b0);
    drain();

    // random phases over several register settings
    for (int p = 0; p < 6; p++) begin
      write_cfg(CfgWindow, 16'(wins[p]));
      write_cfg(CfgPingLim, ($urandom_range(3) == 0) ? 16'd0 :
                ($urandom_range(1) ? 16'hFFFF : 16'($urandom_range(500))));
      write_cfg(CfgJitLim, ($urandom_range(3) == 0) ? 16'd0 :
                ($urandom_range(1) ? 16'hFFFF : 16'($urandom_range(200))));
      random_stall = (p != 2);
      for (int i = 0; i < 300; i++) begin
        if ($urandom_range(9) == 0) cid = 8'($urandom_range(255));
        else cid = 8'($urandom_range(5));
        send_item(($urandom_range(29) == 0) ? OpClear : OpSample, cid, rand_ping(),
                  ($urandom_range(9) != 0));
      end
      drain();
    end

    $display("sent %0d items, %0d results checked, %0d from full windows",
             items_sent, board.results_seen, board.full_seen);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", board.mismatches,
               board.pending.size());
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

`default_nettype wire
